// ----- design/i2cms_pkg.sv -----
package i2cms_pkg;

  localparam int SEND_DEPTH = 32;
  localparam int STORE_IDX_W = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;
  localparam logic [1:0] OP_ERROR = 2'd3;

  localparam logic [1:0] MODE_WRITE      = 2'd0;
  localparam logic [1:0] MODE_READ       = 2'd1;
  localparam logic [1:0] MODE_WRITE_READ = 2'd2;

  localparam logic [1:0] BUF_IRQ_KEEP    = 2'd0;
  localparam logic [1:0] BUF_IRQ_ENABLE  = 2'd1;
  localparam logic [1:0] BUF_IRQ_DISABLE = 2'd2;

  localparam logic [2:0] NOTICE_NONE        = 3'd0;
  localparam logic [2:0] NOTICE_WRITE_START = 3'd1;
  localparam logic [2:0] NOTICE_READ_START  = 3'd2;
  localparam logic [2:0] NOTICE_WRITE_DONE  = 3'd3;
  localparam logic [2:0] NOTICE_READ_DONE   = 3'd4;
  localparam logic [2:0] NOTICE_ERROR       = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  mode;
    logic [6:0]  target_address;
    logic [5:0]  send_count;
    logic [15:0] receive_count;
    logic [4:0]  load_slot;
    logic [7:0]  data_byte;
    logic        start_sent;
    logic        address_done;
    logic        tx_empty;
    logic        rx_full;
    logic        byte_finished;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic        write_valid;
    logic [7:0]  write_byte;
    logic        nack_next;
    logic        gen_start;
    logic        gen_stop;
    logic [1:0]  buffer_irq;
    logic        event_irq_off;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic [15:0] rx_position;
    logic [2:0]  notice;
  } out_t;

  // Event flags after priority resolution: start and address hits stand alone; tx may join rx or fin
  typedef struct packed {
    logic start_hit;
    logic addr_hit;
    logic tx_hit;
    logic rx_hit;
    logic fin_hit;
  } evt_t;

  typedef struct packed {
    logic        is_load;
    logic        is_start;
    logic        is_event;
    logic        is_error;
    logic        load_ok;
    logic        start_ok;
    logic [1:0]  mode;
    logic [6:0]  target_address;
    logic [5:0]  send_count;
    logic [15:0] receive_count;
    logic [STORE_IDX_W-1:0] load_idx;
    logic [7:0]  data_byte;
    evt_t        evt;
  } cmd_t;

endpackage

// ----- design/i2cms_front.sv -----
module i2cms_front (
  input  i2cms_pkg::in_t  item,
  output i2cms_pkg::cmd_t cmd
);

  logic [8:0] slot_ext;
  logic       send_in_range;

  assign slot_ext      = {4'b0, item.load_slot};
  assign send_in_range = 32'(item.send_count) <= i2cms_pkg::SEND_DEPTH;

  always_comb begin
    cmd                = '0;
    cmd.mode           = item.mode;
    cmd.target_address = item.target_address;
    cmd.send_count     = item.send_count;
    cmd.receive_count  = item.receive_count;
    cmd.load_idx       = slot_ext[i2cms_pkg::STORE_IDX_W-1:0];
    cmd.data_byte      = item.data_byte;
    cmd.load_ok        = 32'(item.load_slot) < i2cms_pkg::SEND_DEPTH;

    unique case (item.op)
      i2cms_pkg::OP_LOAD:  cmd.is_load  = 1'b1;
      i2cms_pkg::OP_START: cmd.is_start = 1'b1;
      i2cms_pkg::OP_EVENT: cmd.is_event = 1'b1;
      default:             cmd.is_error = 1'b1;
    endcase

    unique case (item.mode)
      i2cms_pkg::MODE_WRITE:
        cmd.start_ok = (item.send_count != '0) && send_in_range;
      i2cms_pkg::MODE_READ:
        cmd.start_ok = item.receive_count != '0;
      i2cms_pkg::MODE_WRITE_READ:
        cmd.start_ok = send_in_range;
      default:
        cmd.start_ok = 1'b0;
    endcase

    // start sent wins outright, then address done; rx full masks byte finished
    cmd.evt.start_hit = item.start_sent;
    cmd.evt.addr_hit  = !item.start_sent && item.address_done;
    cmd.evt.tx_hit    = !item.start_sent && !item.address_done && item.tx_empty;
    cmd.evt.rx_hit    = !item.start_sent && !item.address_done && item.rx_full;
    cmd.evt.fin_hit   = !item.start_sent && !item.address_done && !item.rx_full
                        && item.byte_finished;
  end

endmodule

// ----- design/i2cms_queue.sv -----
module i2cms_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2cms_pkg::cmd_t push_data,
  input  logic            pop,
  output i2cms_pkg::cmd_t head,
  output logic            not_empty,
  output logic            full,
  output logic [i2cms_pkg::QUEUE_CNT_W-1:0] count
);

  i2cms_pkg::cmd_t slots_r [i2cms_pkg::QUEUE_DEPTH];
  logic [i2cms_pkg::QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [i2cms_pkg::QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [i2cms_pkg::QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign head      = slots_r[rd_ptr_r];
  assign not_empty = count_r != '0;
  assign full      = count_r == i2cms_pkg::QUEUE_CNT_W'(i2cms_pkg::QUEUE_DEPTH);
  assign count     = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == i2cms_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == i2cms_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/i2cms_back.sv -----
module i2cms_back (
  input  logic            clk,
  input  logic            rst_n,
  input  i2cms_pkg::cmd_t cmd,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cms_pkg::out_t out_data
);

  logic        busy_r, busy_nxt;
  logic        reading_r, reading_nxt;
  logic [15:0] position_r, position_nxt;
  logic [5:0]  send_total_r, send_total_nxt;
  logic [15:0] receive_total_r, receive_total_nxt;
  logic [6:0]  peer_r, peer_nxt;

  logic [7:0]  store_r [i2cms_pkg::SEND_DEPTH];
  logic        store_we;
  logic [7:0]  store_rdata;

  logic        out_valid_r, out_valid_nxt;
  i2cms_pkg::out_t out_data_r;
  i2cms_pkg::out_t res;

  logic        tx_done;
  logic [15:0] pos_inc;

  assign cmd_pop     = cmd_valid && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;
  assign store_rdata = store_r[position_r[i2cms_pkg::STORE_IDX_W-1:0]];
  assign store_we    = cmd_pop && cmd.is_load && cmd.load_ok;
  assign pos_inc     = position_r + 16'd1;

  always_comb begin
    res               = '0;
    busy_nxt          = busy_r;
    reading_nxt       = reading_r;
    position_nxt      = position_r;
    send_total_nxt    = send_total_r;
    receive_total_nxt = receive_total_r;
    peer_nxt          = peer_r;
    tx_done           = position_r >= 16'(send_total_r);

    if (cmd.is_start) begin
      if (!busy_r && cmd.start_ok) begin
        reading_nxt       = cmd.mode == i2cms_pkg::MODE_READ;
        send_total_nxt    = (cmd.mode == i2cms_pkg::MODE_READ) ? '0 : cmd.send_count;
        receive_total_nxt = (cmd.mode == i2cms_pkg::MODE_WRITE) ? '0 : cmd.receive_count;
        peer_nxt          = cmd.target_address;
        position_nxt      = '0;
        busy_nxt          = 1'b1;
        res.accepted      = 1'b1;
        res.gen_start     = 1'b1;
        res.notice        = (cmd.mode == i2cms_pkg::MODE_READ) ?
                            i2cms_pkg::NOTICE_READ_START : i2cms_pkg::NOTICE_WRITE_START;
      end
    end else if (cmd.is_error) begin
      if (busy_r) begin
        busy_nxt   = 1'b0;
        res.notice = i2cms_pkg::NOTICE_ERROR;
      end
    end else if (cmd.is_event && busy_r) begin
      if (cmd.evt.start_hit) begin
        res.write_valid = 1'b1;
        res.write_byte  = {peer_r, reading_r};
        res.buffer_irq  = i2cms_pkg::BUF_IRQ_ENABLE;
      end else if (cmd.evt.addr_hit) begin
        res.nack_next = reading_r && (receive_total_r == 16'd1);
      end else begin
        if (cmd.evt.tx_hit && !reading_r) begin
          if (!tx_done) begin
            res.write_valid = 1'b1;
            res.write_byte  = store_rdata;
            position_nxt    = pos_inc;
          end else begin
            res.buffer_irq = i2cms_pkg::BUF_IRQ_DISABLE;
          end
        end
        if (cmd.evt.rx_hit) begin
          if (reading_r && (position_r < receive_total_r)) begin
            res.rx_valid    = 1'b1;
            res.rx_byte     = cmd.data_byte;
            res.rx_position = position_r;
            position_nxt    = pos_inc;
            res.nack_next   = pos_inc == (receive_total_r - 16'd1);
            if (pos_inc >= receive_total_r) begin
              res.gen_stop      = 1'b1;
              res.buffer_irq    = i2cms_pkg::BUF_IRQ_DISABLE;
              res.event_irq_off = 1'b1;
              res.notice        = i2cms_pkg::NOTICE_READ_DONE;
              busy_nxt          = 1'b0;
            end
          end
        end else if (cmd.evt.fin_hit) begin
          // judge against the position after a byte sent in this same event
          if (!reading_r && (position_nxt >= 16'(send_total_r))) begin
            if (receive_total_r != '0) begin
              position_nxt  = '0;
              reading_nxt   = 1'b1;
              res.gen_start = 1'b1;
            end else begin
              res.gen_stop      = 1'b1;
              res.buffer_irq    = i2cms_pkg::BUF_IRQ_DISABLE;
              res.event_irq_off = 1'b1;
              res.notice        = i2cms_pkg::NOTICE_WRITE_DONE;
              busy_nxt          = 1'b0;
            end
          end
        end
      end
    end

    if (cmd_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      reading_r       <= 1'b0;
      position_r      <= '0;
      send_total_r    <= '0;
      receive_total_r <= '0;
      peer_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd_pop) begin
        busy_r          <= busy_nxt;
        reading_r       <= reading_nxt;
        position_r      <= position_nxt;
        send_total_r    <= send_total_nxt;
        receive_total_r <= receive_total_nxt;
        peer_r          <= peer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_data_r <= res;
    end
    if (store_we) begin
      store_r[cmd.load_idx] <= cmd.data_byte;
    end
  end

endmodule

// ----- design/i2c_master_transfer_sequencer.sv -----
// Channel  Ports                          Payload
// -------  -----------------------------  ---------------------------
// input    in_valid / in_ready            in_data  (i2cms_pkg::in_t)
// result   out_valid / out_ready          out_data (i2cms_pkg::out_t)
//
// One item per cycle sustained while out_ready stays high; each result is registered
// first in the queue and then in the output register after its item's acceptance (front
// decode into the queue, back execute into the output register). The two-entry
// queue plus the output register hold three items before a stalled result side
// drops in_ready. Reset is synchronous, active low, and clears the queue,
// transfer state and result valid; the transmit store is not cleared.
module i2c_master_transfer_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cms_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cms_pkg::out_t out_data
);

  i2cms_pkg::cmd_t front_cmd;
  i2cms_pkg::cmd_t q_head;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;
  logic            q_full;
  logic [i2cms_pkg::QUEUE_CNT_W-1:0] q_count;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  i2cms_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  i2cms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full),
    .count     (q_count)
  );

  i2cms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_head),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_count) <= i2cms_pkg::QUEUE_DEPTH)
    else $error("queue count exceeds depth");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result appeared without a queue pop");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.accepted) |-> (out_data.gen_start &&
      (out_data.notice == i2cms_pkg::NOTICE_WRITE_START ||
       out_data.notice == i2cms_pkg::NOTICE_READ_START)))
    else $error("accepted start without start condition and notice");

  a_rx_notice: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rx_valid) |-> (!out_data.write_valid &&
      (out_data.notice == i2cms_pkg::NOTICE_NONE ||
       out_data.notice == i2cms_pkg::NOTICE_READ_DONE)))
    else $error("received byte delivered with conflicting actions");
`endif

endmodule
